// File: design/huff_pkg.sv
// Package for the Huffman code builder and encoder.
// Holds the item types and the operation and result kind codes.
// No dependencies.
package huff_pkg;

    localparam logic OP_COUNT    = 1'b0;
    localparam logic OP_ENCODE   = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_CODE   = 1'b1;

    localparam int CODE_BITS_W = 48;
    localparam int CODE_LEN_W  = 6;
    localparam int ALPHA_W     = 9;

    typedef struct packed {
        logic       operation;
        logic [7:0] symbol;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic                   kind;
        logic [CODE_BITS_W-1:0] code_bits;
        logic [CODE_LEN_W-1:0]  code_length;
        logic                   known;
        logic [ALPHA_W-1:0]     alphabet_size;
        logic                   count_saturated;
    } res_t;

endpackage

// File: design/huff_if.sv
// Valid/ready channel interfaces for command and result items.
// Depends on huff_pkg.
interface huff_cmd_if;
    logic          valid;
    logic          ready;
    huff_pkg::cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface huff_res_if;
    logic          valid;
    logic          ready;
    huff_pkg::res_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/huffman_code_builder_encoder.sv
// Huffman code builder and encoder: counting, tree build and code table lookup.
// A count item without last holds the command channel while its count is updated; an
// encode result is registered after the code table read. The next item can be taken in
// the cycle after the result is taken. A last count item starts a build over the n
// distinct symbols, sorting them in the sorted-list memory and walking the built tree.
// Reset clears control state and count and code valid bits at once. Needs huff_pkg, huff_if.
module huffman_code_builder_encoder #(
    parameter int ALPHABET_SIZE = 256,
    parameter int COUNT_WIDTH   = 32,
    parameter int MAX_CODE_LEN  = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    huff_cmd_if.sink      cmd,
    huff_res_if.source    res
);
    import huff_pkg::*;

    localparam int IDX_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int N_W    = $clog2(ALPHABET_SIZE + 1);
    localparam int NODES  = 2 * ALPHABET_SIZE - 1;
    localparam int NODE_W = $clog2(NODES);
    localparam int CAP    = (MAX_CODE_LEN < CODE_BITS_W) ? MAX_CODE_LEN : CODE_BITS_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CNT  = 5'd1;
    localparam logic [4:0] S_ENC  = 5'd2;
    localparam logic [4:0] S_BI0  = 5'd3;
    localparam logic [4:0] S_BI1  = 5'd4;
    localparam logic [4:0] S_BI2  = 5'd5;
    localparam logic [4:0] S_SS0  = 5'd6;
    localparam logic [4:0] S_SS1  = 5'd7;
    localparam logic [4:0] S_SS2  = 5'd8;
    localparam logic [4:0] S_SS3  = 5'd9;
    localparam logic [4:0] S_MG0  = 5'd10;
    localparam logic [4:0] S_MG1  = 5'd11;
    localparam logic [4:0] S_MG2  = 5'd12;
    localparam logic [4:0] S_MG3  = 5'd13;
    localparam logic [4:0] S_MG4  = 5'd14;
    localparam logic [4:0] S_MG5  = 5'd15;
    localparam logic [4:0] S_MG6  = 5'd16;
    localparam logic [4:0] S_ROOT = 5'd17;
    localparam logic [4:0] S_CW0  = 5'd18;
    localparam logic [4:0] S_CW1  = 5'd19;
    localparam logic [4:0] S_CW2  = 5'd20;
    localparam logic [4:0] S_CW3  = 5'd21;
    localparam logic [4:0] S_RPT  = 5'd22;
    localparam logic [4:0] S_BST  = 5'd23;

    typedef struct packed {
        logic [NODE_W-1:0]      idx;
        logic [COUNT_WIDTH-1:0] cnt;
    } ent_t;

    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic              branch;
    } tnode_t;

    typedef struct packed {
        logic [CODE_LEN_W-1:0]  len;
        logic [CODE_BITS_W-1:0] bits;
    } code_t;

    logic [COUNT_WIDTH-1:0] count_ram_reg [ALPHABET_SIZE];
    logic [IDX_W-1:0]       order_ram_reg [ALPHABET_SIZE];
    ent_t                   sort_ram_reg  [ALPHABET_SIZE];
    tnode_t                 tree_ram_reg  [NODES];
    code_t                  code_ram_reg  [ALPHABET_SIZE];

    logic [COUNT_WIDTH-1:0] cnt_rd_reg;
    logic [IDX_W-1:0]       ord_rd_reg;
    ent_t                   srt_rd_reg;
    tnode_t                 tre_rd_reg;
    code_t                  cod_rd_reg;

    logic                   cnt_we, cnt_re, ord_we, ord_re, srt_we, srt_re;
    logic                   tre_we, tre_re, cod_we, cod_re;
    logic [IDX_W-1:0]       cnt_waddr, cnt_raddr, ord_waddr, ord_raddr;
    logic [IDX_W-1:0]       srt_waddr, srt_raddr, cod_waddr, cod_raddr;
    logic [NODE_W-1:0]      tre_waddr, tre_raddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic [IDX_W-1:0]       ord_wdata;
    ent_t                   srt_wdata;
    tnode_t                 tre_wdata;
    code_t                  cod_wdata;

    logic [4:0]             state_reg, state_next;
    logic [7:0]             sym_reg, sym_next;
    logic                   last_reg, last_next;
    logic [N_W-1:0]         i_reg, i_next, j_reg, j_next, len_reg, len_next;
    logic [N_W-1:0]         src_reg, src_next, w_reg, w_next, depth_reg, depth_next;
    logic [N_W-1:0]         distinct_reg, distinct_next, built_reg, built_next;
    logic [NODE_W-1:0]      nxt_reg, nxt_next, root_reg, root_next, node_reg, node_next;
    ent_t                   piv_reg, piv_next, a_reg, a_next, e_reg, e_next;
    logic [COUNT_WIDTH-1:0] sum_reg, sum_next;
    logic                   ins_reg, ins_next, sat_reg, sat_next, fresh_reg, fresh_next;
    logic [CAP-1:0]         acc_reg, acc_next;
    logic [ALPHABET_SIZE-1:0] cvld_reg, cvld_next, kvld_reg, kvld_next;
    logic                   out_valid_reg, out_valid_next;
    res_t                   out_reg, out_next;

    logic                   cmd_in_range, sym_in_range;
    logic [COUNT_WIDTH:0]   sum_wide;
    logic [CODE_LEN_W-1:0]  keep;

    assign cmd_in_range = {1'b0, cmd.data.symbol} < 9'(ALPHABET_SIZE);
    assign sym_in_range = {1'b0, sym_reg} < 9'(ALPHABET_SIZE);
    assign sum_wide     = {1'b0, a_reg.cnt} + {1'b0, srt_rd_reg.cnt};
    assign keep         = (32'(depth_reg) >= CAP) ? CODE_LEN_W'(CAP) : CODE_LEN_W'(depth_reg);

    assign cmd.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_ram_reg[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rd_reg <= count_ram_reg[cnt_raddr];
        end
        if (ord_we)
        begin
            order_ram_reg[ord_waddr] <= ord_wdata;
        end
        if (ord_re)
        begin
            ord_rd_reg <= order_ram_reg[ord_raddr];
        end
        if (srt_we)
        begin
            sort_ram_reg[srt_waddr] <= srt_wdata;
        end
        if (srt_re)
        begin
            srt_rd_reg <= sort_ram_reg[srt_raddr];
        end
        if (tre_we)
        begin
            tree_ram_reg[tre_waddr] <= tre_wdata;
        end
        if (tre_re)
        begin
            tre_rd_reg <= tree_ram_reg[tre_raddr];
        end
        if (cod_we)
        begin
            code_ram_reg[cod_waddr] <= cod_wdata;
        end
        if (cod_re)
        begin
            cod_rd_reg <= code_ram_reg[cod_raddr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        len_next       = len_reg;
        src_next       = src_reg;
        w_next         = w_reg;
        depth_next     = depth_reg;
        distinct_next  = distinct_reg;
        built_next     = built_reg;
        nxt_next       = nxt_reg;
        root_next      = root_reg;
        node_next      = node_reg;
        piv_next       = piv_reg;
        a_next         = a_reg;
        e_next         = e_reg;
        sum_next       = sum_reg;
        ins_next       = ins_reg;
        sat_next       = sat_reg;
        fresh_next     = fresh_reg;
        acc_next       = acc_reg;
        cvld_next      = cvld_reg;
        kvld_next      = kvld_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        cnt_we = 1'b0; cnt_re = 1'b0; cnt_waddr = sym_reg[IDX_W-1:0];
        cnt_raddr = cmd.data.symbol[IDX_W-1:0]; cnt_wdata = '0;
        ord_we = 1'b0; ord_re = 1'b0; ord_waddr = distinct_reg[IDX_W-1:0];
        ord_raddr = i_reg[IDX_W-1:0]; ord_wdata = sym_reg[IDX_W-1:0];
        srt_we = 1'b0; srt_re = 1'b0; srt_waddr = w_reg[IDX_W-1:0];
        srt_raddr = '0; srt_wdata = '0;
        tre_we = 1'b0; tre_re = 1'b0; tre_waddr = a_reg.idx;
        tre_raddr = node_reg; tre_wdata = '0;
        cod_we = 1'b0; cod_re = 1'b0; cod_waddr = ord_rd_reg;
        cod_raddr = cmd.data.symbol[IDX_W-1:0]; cod_wdata = '0;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && cmd.ready)
                begin
                    sym_next  = cmd.data.symbol;
                    last_next = cmd.data.last;
                    if (cmd.data.operation == OP_COUNT)
                    begin
                        if (fresh_reg)
                        begin
                            cvld_next     = '0;
                            kvld_next     = '0;
                            distinct_next = '0;
                            sat_next      = 1'b0;
                            fresh_next    = 1'b0;
                        end
                        if (cmd_in_range)
                        begin
                            cnt_re     = 1'b1;
                            state_next = S_CNT;
                        end
                        else if (cmd.data.last)
                        begin
                            state_next = S_BST;
                        end
                    end
                    else
                    begin
                        cod_re     = 1'b1;
                        state_next = S_ENC;
                    end
                end
            end
            S_CNT:
            begin
                if (!cvld_reg[sym_reg[IDX_W-1:0]])
                begin
                    cnt_we = 1'b1;
                    cnt_wdata = COUNT_WIDTH'(1);
                    cvld_next[sym_reg[IDX_W-1:0]] = 1'b1;
                    ord_we = 1'b1;
                    distinct_next = distinct_reg + 1'b1;
                end
                else if (cnt_rd_reg == COUNT_MAX)
                begin
                    sat_next = 1'b1;
                end
                else
                begin
                    cnt_we = 1'b1;
                    cnt_wdata = cnt_rd_reg + 1'b1;
                end
                state_next = last_reg ? S_BST : S_IDLE;
            end
            S_ENC:
            begin
                out_valid_next        = 1'b1;
                out_next              = '0;
                out_next.kind         = KIND_CODE;
                if (sym_in_range && kvld_reg[sym_reg[IDX_W-1:0]])
                begin
                    out_next.code_bits   = cod_rd_reg.bits;
                    out_next.code_length = cod_rd_reg.len;
                    out_next.known       = 1'b1;
                end
                out_next.alphabet_size   = ALPHA_W'(built_reg);
                out_next.count_saturated = sat_reg;
                state_next = S_IDLE;
            end
            S_BST:
            begin
                i_next     = '0;
                state_next = (distinct_reg == '0) ? S_RPT : S_BI0;
            end
            S_BI0:
            begin
                ord_re     = 1'b1;
                state_next = S_BI1;
            end
            S_BI1:
            begin
                cnt_re     = 1'b1;
                cnt_raddr  = ord_rd_reg;
                state_next = S_BI2;
            end
            S_BI2:
            begin
                srt_we    = 1'b1;
                srt_waddr = i_reg[IDX_W-1:0];
                srt_wdata = '{idx: NODE_W'(i_reg), cnt: cnt_rd_reg};
                i_next    = i_reg + 1'b1;
                if (i_reg + 1'b1 == distinct_reg)
                begin
                    i_next     = N_W'(1);
                    state_next = S_SS0;
                end
                else
                begin
                    state_next = S_BI0;
                end
            end
            S_SS0:
            begin
                if (i_reg >= distinct_reg)
                begin
                    len_next   = distinct_reg;
                    nxt_next   = NODE_W'(distinct_reg);
                    state_next = S_MG0;
                end
                else
                begin
                    srt_re     = 1'b1;
                    srt_raddr  = i_reg[IDX_W-1:0];
                    state_next = S_SS1;
                end
            end
            S_SS1:
            begin
                piv_next   = srt_rd_reg;
                j_next     = i_reg;
                state_next = S_SS2;
            end
            S_SS2:
            begin
                if (j_reg == '0)
                begin
                    srt_we     = 1'b1;
                    srt_waddr  = j_reg[IDX_W-1:0];
                    srt_wdata  = piv_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SS0;
                end
                else
                begin
                    srt_re     = 1'b1;
                    srt_raddr  = IDX_W'(j_reg - 1'b1);
                    state_next = S_SS3;
                end
            end
            S_SS3:
            begin
                srt_we    = 1'b1;
                srt_waddr = j_reg[IDX_W-1:0];
                if (srt_rd_reg.cnt > piv_reg.cnt)
                begin
                    srt_wdata  = srt_rd_reg;
                    j_next     = j_reg - 1'b1;
                    state_next = S_SS2;
                end
                else
                begin
                    srt_wdata  = piv_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SS0;
                end
            end
            S_MG0:
            begin
                srt_re    = 1'b1;
                srt_raddr = '0;
                state_next = (len_reg <= N_W'(1)) ? S_ROOT : S_MG1;
            end
            S_MG1:
            begin
                a_next     = srt_rd_reg;
                srt_re     = 1'b1;
                srt_raddr  = IDX_W'(1);
                state_next = S_MG2;
            end
            S_MG2:
            begin
                if (sum_wide[COUNT_WIDTH])
                begin
                    sum_next = COUNT_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_wide[COUNT_WIDTH-1:0];
                end
                tre_we     = 1'b1;
                tre_waddr  = a_reg.idx;
                tre_wdata  = '{parent: nxt_reg, branch: 1'b0};
                state_next = S_MG3;
            end
            S_MG3:
            begin
                tre_we     = 1'b1;
                tre_waddr  = srt_rd_reg.idx;
                tre_wdata  = '{parent: nxt_reg, branch: 1'b1};
                src_next   = N_W'(2);
                w_next     = '0;
                ins_next   = 1'b0;
                state_next = S_MG4;
            end
            S_MG4:
            begin
                if (src_reg >= len_reg)
                begin
                    if (!ins_reg)
                    begin
                        srt_we    = 1'b1;
                        srt_wdata = '{idx: nxt_reg, cnt: sum_reg};
                    end
                    len_next   = len_reg - 1'b1;
                    nxt_next   = nxt_reg + 1'b1;
                    state_next = S_MG0;
                end
                else
                begin
                    srt_re     = 1'b1;
                    srt_raddr  = src_reg[IDX_W-1:0];
                    state_next = S_MG5;
                end
            end
            S_MG5:
            begin
                srt_we = 1'b1;
                e_next = srt_rd_reg;
                w_next = w_reg + 1'b1;
                if (!ins_reg && (srt_rd_reg.cnt >= sum_reg))
                begin
                    srt_wdata  = '{idx: nxt_reg, cnt: sum_reg};
                    ins_next   = 1'b1;
                    state_next = S_MG6;
                end
                else
                begin
                    srt_wdata  = srt_rd_reg;
                    src_next   = src_reg + 1'b1;
                    state_next = S_MG4;
                end
            end
            S_MG6:
            begin
                srt_we     = 1'b1;
                srt_wdata  = e_reg;
                w_next     = w_reg + 1'b1;
                src_next   = src_reg + 1'b1;
                state_next = S_MG4;
            end
            S_ROOT:
            begin
                root_next  = srt_rd_reg.idx;
                i_next     = '0;
                state_next = S_CW0;
            end
            S_CW0:
            begin
                if (i_reg >= distinct_reg)
                begin
                    state_next = S_RPT;
                end
                else
                begin
                    ord_re     = 1'b1;
                    node_next  = NODE_W'(i_reg);
                    depth_next = '0;
                    acc_next   = '0;
                    state_next = S_CW1;
                end
            end
            S_CW1:
            begin
                if (node_reg == root_reg)
                begin
                    state_next = S_CW3;
                end
                else
                begin
                    tre_re     = 1'b1;
                    state_next = S_CW2;
                end
            end
            S_CW2:
            begin
                acc_next   = {tre_rd_reg.branch, acc_reg[CAP-1:1]};
                depth_next = depth_reg + 1'b1;
                node_next  = tre_rd_reg.parent;
                state_next = S_CW1;
            end
            S_CW3:
            begin
                cod_we         = 1'b1;
                cod_wdata.len  = keep;
                cod_wdata.bits = CODE_BITS_W'(acc_reg >> (CODE_LEN_W'(CAP) - keep));
                kvld_next[ord_rd_reg] = 1'b1;
                i_next         = i_reg + 1'b1;
                state_next     = S_CW0;
            end
            S_RPT:
            begin
                out_valid_next           = 1'b1;
                out_next                 = '0;
                out_next.kind            = KIND_REPORT;
                out_next.alphabet_size   = ALPHA_W'(distinct_reg);
                out_next.count_saturated = sat_reg;
                built_next               = distinct_reg;
                fresh_next               = 1'b1;
                state_next               = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            distinct_reg  <= '0;
            built_reg     <= '0;
            sat_reg       <= 1'b0;
            fresh_reg     <= 1'b0;
            cvld_reg      <= '0;
            kvld_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            distinct_reg  <= distinct_next;
            built_reg     <= built_next;
            sat_reg       <= sat_next;
            fresh_reg     <= fresh_next;
            cvld_reg      <= cvld_next;
            kvld_reg      <= kvld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg   <= sym_next;
        last_reg  <= last_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        len_reg   <= len_next;
        src_reg   <= src_next;
        w_reg     <= w_next;
        depth_reg <= depth_next;
        nxt_reg   <= nxt_next;
        root_reg  <= root_next;
        node_reg  <= node_next;
        piv_reg   <= piv_next;
        a_reg     <= a_next;
        e_reg     <= e_next;
        sum_reg   <= sum_next;
        ins_reg   <= ins_next;
        acc_reg   <= acc_next;
        out_reg   <= out_next;
    end

endmodule

// File: design/huff_checker.sv
// Port-level checker for the Huffman code builder and encoder, with its bind.
// Depends on huff_pkg and the top level's channel ports.
module huff_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_ready,
    input logic           res_valid,
    input logic           res_ready,
    input huff_pkg::res_t res_data
);
    import huff_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result item dropped before it was taken");

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !cmd_ready)
        else $error("command item taken while a result item waits");

    a_unknown_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.kind == KIND_CODE && !res_data.known
        |-> res_data.code_length == '0 && res_data.code_bits == '0)
        else $error("unknown symbol carries a code word");

    a_report_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.kind == KIND_REPORT
        |-> res_data.code_length == '0 && !res_data.known)
        else $error("build report carries a code word");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.code_length <= CODE_LEN_W'(CODE_BITS_W))
        else $error("code length exceeds the code word width");

endmodule

bind huffman_code_builder_encoder huff_checker u_huff_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);
